FILE: hdl/wfq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfq_pkg: shared types and constants of the weighted fair queue scheduler
// Register indexes, status codes, the queue entry between front and back.
// ----------------------------------------------------------------------------
package wfq_pkg;

  localparam int NumClasses = 4;
  localparam int ClassDepth = 64;
  localparam int VtFracBits = 16;
  localparam int VtBits     = 48;
  localparam int SumMax     = 1023;

  localparam logic [2:0] RegWeight0  = 3'd0;
  localparam logic [2:0] RegWeight3  = 3'd3;
  localparam logic [2:0] RegCapacity = 3'd4;
  localparam logic [2:0] RegLinkRate = 3'd5;

  localparam logic [1:0] StAccepted = 2'd0;
  localparam logic [1:0] StDropped  = 2'd1;
  localparam logic [1:0] StDequeued = 2'd2;
  localparam logic [1:0] StEmpty    = 2'd3;

  localparam logic ReqEnqueue = 1'b0;
  localparam logic ReqDequeue = 1'b1;

  // One request passed from front to back
  typedef struct packed {
    logic        req_type;
    logic [1:0]  class_index;
    logic [16:0] packet_bits;
    logic [15:0] packet_tag;
    logic [31:0] now_ticks;
  } req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ENQ_VT,
    S_ENQ_TAG,
    S_ENQ_DIV,
    S_ENQ_WR,
    S_DEQ_RD,
    S_DEQ_SCAN,
    S_DEQ_DESC,
    S_DEQ_VT,
    S_DEQ_FIN,
    S_OUT
  } state_e;

endpackage

FILE: hdl/wfq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfq_ram: generic single-port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module wfq_ram #(
  parameter int Width = 16,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule

FILE: hdl/wfq_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfq_div: restoring divider, one quotient bit per cycle
// Quotient of a 48-bit dividend by a 24-bit divisor.
// ----------------------------------------------------------------------------
module wfq_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [47:0] dividend_i,
  input  logic [23:0] divisor_i,
  output logic        done_o,
  output logic [47:0] quot_o
);
  logic [47:0] quot_q, quot_d;
  logic [23:0] rem_q, rem_d;
  logic [23:0] dsr_q, dsr_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [24:0] trial;
  logic [24:0] diff;

  assign diff = trial - {1'b0, dsr_q};

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q, quot_q[47]};
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
      cnt_d  = 6'd48;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // remainder stays below the divisor, so 24 bits hold it
      if (trial >= {1'b0, dsr_q}) begin
        rem_d  = diff[23:0];
        quot_d = {quot_q[46:0], 1'b1};
      end else begin
        rem_d  = trial[23:0];
        quot_d = {quot_q[46:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dsr_q  <= dsr_d;
  end

  assign done_o = busy_q && (cnt_q == 6'd1);
  assign quot_o = quot_d;
endmodule

FILE: hdl/wfq_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfq_front: request intake and queue
// Two-entry queue of requests that decouples the input from the sequencer.
// ----------------------------------------------------------------------------
module wfq_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  wfq_pkg::req_t in_req_i,
  output logic          q_valid_o,
  input  logic          q_pop_i,
  output wfq_pkg::req_t q_req_o
);
  wfq_pkg::req_t ent_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       rd_q, rd_d, wr_q, wr_d;
  logic       push;

  assign in_ready_o = cnt_q != 2'd2;
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = cnt_q != 2'd0;
  assign q_req_o    = ent_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    rd_d  = rd_q;
    wr_d  = wr_q;
    if (push) wr_d = ~wr_q;
    if (q_pop_i) rd_d = ~rd_q;
    if (push && !q_pop_i) cnt_d = cnt_q + 2'd1;
    else if (!push && q_pop_i) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      rd_q  <= rd_d;
      wr_q  <= wr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) ent_q[wr_q] <= in_req_i;
  end
endmodule

FILE: hdl/wfq_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfq_back: scheduling sequencer
// Carries out one enqueue or dequeue: virtual time, tags, stores, result.
// ----------------------------------------------------------------------------
module wfq_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  output logic          q_pop_o,
  input  wfq_pkg::req_t q_req_i,
  input  logic [7:0]    weight_i [wfq_pkg::NumClasses],
  input  logic [6:0]    capacity_i,
  input  logic [15:0]   rate_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [28:0]   out_data_o
);
  localparam int NC  = wfq_pkg::NumClasses;
  localparam int CD  = wfq_pkg::ClassDepth;
  localparam int CW  = $clog2(NC);
  localparam int PW  = $clog2(CD);
  localparam int AW  = CW + PW;
  localparam int VB  = wfq_pkg::VtBits;
  localparam int FB  = wfq_pkg::VtFracBits;
  localparam logic [VB-1:0] VtMax = '1;

  wfq_pkg::state_e st_q, st_d;
  wfq_pkg::req_t   r_q, r_d;
  logic [VB-1:0] lastf_q [NC];
  logic [VB-1:0] lastf_d [NC];
  logic [PW:0]   blog_q [NC];
  logic [PW:0]   blog_d [NC];
  logic [PW-1:0] head_q [NC];
  logic [PW-1:0] head_d [NC];
  logic [PW-1:0] tail_q [NC];
  logic [PW-1:0] tail_d [NC];
  logic [9:0]  sum_q, sum_d;
  logic [VB-1:0] vt_q, vt_d, best_q, best_d, base_q, base_d;
  logic [31:0] lut_q, lut_d;
  logic        idle_q, idle_d;
  logic [8:0]  tot_q, tot_d;
  logic [CW:0] scan_q, scan_d;
  logic [CW-1:0] sel_q, sel_d;
  logic        found_q, found_d;
  logic [1:0]  ost_q, ost_d;
  logic [1:0]  ocls_q, ocls_d;
  logic [15:0] otag_q, otag_d;
  logic        ovalid_q, ovalid_d;
  logic        vt_pend_q, vt_pend_d;

  logic        ram_we;
  logic [AW-1:0] ram_addr;
  logic [VB-1:0] tag_rd;
  logic [15:0]   desc_rd;
  logic          div_start, div_done;
  logic [47:0]   div_dvd, div_q;
  logic [23:0]   div_dsr;

  logic [CW-1:0] rcls;
  logic [7:0]    wr_w;
  logic [15:0]   rate_eff;
  logic [31:0]   elapsed;
  logic [VB:0]   vsum;
  logic [VB:0]   fsum;
  logic [CW-1:0] scls;

  function automatic logic [7:0] eff_w(input logic [7:0] w);
    eff_w = (w == 8'd0) ? 8'd1 : w;
  endfunction

  assign rcls     = r_q.class_index[CW-1:0];
  assign wr_w     = eff_w(weight_i[rcls]);
  assign rate_eff = (rate_i == 16'd0) ? 16'd1 : rate_i;
  assign elapsed  = (r_q.now_ticks >= lut_q) ? r_q.now_ticks - lut_q : 32'd0;
  assign vsum     = {1'b0, vt_q} + {1'b0, div_q};
  assign fsum     = {1'b0, base_q} + {1'b0, div_q};
  assign scls     = scan_q[CW-1:0];

  wfq_ram #(.Width(VB), .Depth(NC * CD)) u_tag_ram (
    .clk_i(clk_i), .we_i(ram_we), .addr_i(ram_addr), .wdata_i(lastf_q[rcls]),
    .rdata_o(tag_rd)
  );
  wfq_ram #(.Width(16), .Depth(NC * CD)) u_desc_ram (
    .clk_i(clk_i), .we_i(ram_we), .addr_i(ram_addr), .wdata_i(r_q.packet_tag),
    .rdata_o(desc_rd)
  );
  wfq_div u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(div_start), .dividend_i(div_dvd),
    .divisor_i(div_dsr), .done_o(div_done), .quot_o(div_q)
  );

  always_comb begin
    st_d = st_q; r_d = r_q; lastf_d = lastf_q; blog_d = blog_q;
    head_d = head_q; tail_d = tail_q; sum_d = sum_q; vt_d = vt_q;
    best_d = best_q; base_d = base_q; lut_d = lut_q; idle_d = idle_q;
    tot_d = tot_q; scan_d = scan_q; sel_d = sel_q; found_d = found_q;
    ost_d = ost_q; ocls_d = ocls_q; otag_d = otag_q; ovalid_d = ovalid_q;
    vt_pend_d = vt_pend_q;
    q_pop_o = 1'b0; ram_we = 1'b0; ram_addr = {rcls, tail_q[rcls]};
    div_start = 1'b0;
    div_dvd = {elapsed, FB'(0)} ;
    div_dsr = {14'd0, sum_q};
    if (ovalid_q && out_ready_i) ovalid_d = 1'b0;
    case (st_q)
      wfq_pkg::S_IDLE: begin
        if (q_valid_i && !ovalid_q) begin
          q_pop_o = 1'b1;
          r_d = q_req_i;
          st_d = (q_req_i.req_type == wfq_pkg::ReqEnqueue) ? wfq_pkg::S_ENQ_VT
                                                           : wfq_pkg::S_DEQ_RD;
        end
      end
      wfq_pkg::S_ENQ_VT: begin
        ocls_d = r_q.class_index;
        otag_d = 16'd0;
        if (32'(r_q.class_index) >= NC || blog_q[rcls] >= (PW+1)'(CD) ||
            (capacity_i != 7'd0 && 32'(blog_q[rcls]) >= 32'(capacity_i))) begin
          ost_d = wfq_pkg::StDropped;
          st_d = wfq_pkg::S_OUT;
        end else if (idle_q) begin
          lut_d = r_q.now_ticks; vt_d = '0; idle_d = 1'b0;
          st_d = wfq_pkg::S_ENQ_TAG;
        end else begin
          lut_d = r_q.now_ticks;
          if (sum_q != 10'd0) begin
            div_start = 1'b1;
            vt_pend_d = 1'b1;
            st_d = wfq_pkg::S_ENQ_DIV;
          end else st_d = wfq_pkg::S_ENQ_TAG;
        end
      end
      wfq_pkg::S_ENQ_DIV: begin
        if (div_done) begin
          if (vt_pend_q) begin
            vt_d = vsum[VB] ? VtMax : vsum[VB-1:0];
            vt_pend_d = 1'b0;
            st_d = wfq_pkg::S_ENQ_TAG;
          end else begin
            lastf_d[rcls] = fsum[VB] ? VtMax : fsum[VB-1:0];
            st_d = wfq_pkg::S_ENQ_WR;
          end
        end
      end
      wfq_pkg::S_ENQ_TAG: begin
        base_d = (lastf_q[rcls] > vt_q) ? lastf_q[rcls] : vt_q;
        div_start = 1'b1;
        div_dvd = {{(48-17-FB){1'b0}}, r_q.packet_bits, FB'(0)};
        div_dsr = 24'(wr_w) * 24'(rate_eff);
        st_d = wfq_pkg::S_ENQ_DIV;
      end
      wfq_pkg::S_ENQ_WR: begin
        ram_we = 1'b1;
        tail_d[rcls] = (32'(tail_q[rcls]) + 1 >= CD) ? '0 : tail_q[rcls] + 1'b1;
        blog_d[rcls] = blog_q[rcls] + 1'b1;
        if (blog_q[rcls] == '0)
          sum_d = (11'(sum_q) + 11'(wr_w) > 11'(wfq_pkg::SumMax)) ? 10'(wfq_pkg::SumMax)
                  : sum_q + 10'(wr_w);
        tot_d = tot_q + 9'd1;
        ost_d = wfq_pkg::StAccepted;
        st_d = wfq_pkg::S_OUT;
      end
      wfq_pkg::S_DEQ_RD: begin
        scan_d = '0; found_d = 1'b0; sel_d = '0;
        ram_addr = {CW'(0), head_q[0]};
        st_d = wfq_pkg::S_DEQ_SCAN;
      end
      wfq_pkg::S_DEQ_SCAN: begin
        // tag_rd holds the head tag of class scan_q
        if (blog_q[scls] != '0 && (!found_q || tag_rd < best_q)) begin
          found_d = 1'b1; best_d = tag_rd; sel_d = scls;
        end
        if (32'(scan_q) == NC - 1) begin
          ram_addr = {found_d ? sel_d : sel_q, head_q[found_d ? sel_d : sel_q]};
          st_d = wfq_pkg::S_DEQ_DESC;
        end else begin
          scan_d = scan_q + 1'b1;
          ram_addr = {scls + 1'b1, head_q[scls + 1'b1]};
        end
      end
      wfq_pkg::S_DEQ_DESC: begin
        if (!found_q) begin
          ost_d = wfq_pkg::StEmpty; ocls_d = '0; otag_d = '0;
          st_d = wfq_pkg::S_OUT;
        end else begin
          ost_d = wfq_pkg::StDequeued; ocls_d = 2'(sel_q); otag_d = desc_rd;
          head_d[sel_q] = (32'(head_q[sel_q]) + 1 >= CD) ? '0 : head_q[sel_q] + 1'b1;
          lut_d = r_q.now_ticks;
          if (sum_q != 10'd0) begin
            div_start = 1'b1;
            st_d = wfq_pkg::S_DEQ_VT;
          end else st_d = wfq_pkg::S_DEQ_FIN;
        end
      end
      wfq_pkg::S_DEQ_VT: begin
        if (div_done) begin
          vt_d = vsum[VB] ? VtMax : vsum[VB-1:0];
          st_d = wfq_pkg::S_DEQ_FIN;
        end
      end
      wfq_pkg::S_DEQ_FIN: begin
        blog_d[sel_q] = blog_q[sel_q] - 1'b1;
        if (blog_q[sel_q] == (PW+1)'(1))
          sum_d = (sum_q > 10'(eff_w(weight_i[sel_q]))) ?
                  sum_q - 10'(eff_w(weight_i[sel_q])) : 10'd0;
        if (sum_d == 10'd0) begin
          idle_d = 1'b1;
          for (int i = 0; i < NC; i++) lastf_d[i] = '0;
        end
        if (tot_q != 9'd0) tot_d = tot_q - 9'd1;
        st_d = wfq_pkg::S_OUT;
      end
      wfq_pkg::S_OUT: begin
        ovalid_d = 1'b1;
        st_d = wfq_pkg::S_IDLE;
      end
      default: st_d = wfq_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= wfq_pkg::S_IDLE;
      for (int i = 0; i < NC; i++) begin
        lastf_q[i] <= '0; blog_q[i] <= '0; head_q[i] <= '0; tail_q[i] <= '0;
      end
      sum_q <= '0; vt_q <= '0; lut_q <= '0; idle_q <= 1'b1; tot_q <= '0;
      ovalid_q <= 1'b0; vt_pend_q <= 1'b0; found_q <= 1'b0;
    end else begin
      st_q <= st_d; lastf_q <= lastf_d; blog_q <= blog_d; head_q <= head_d;
      tail_q <= tail_d; sum_q <= sum_d; vt_q <= vt_d; lut_q <= lut_d;
      idle_q <= idle_d; tot_q <= tot_d; ovalid_q <= ovalid_d;
      vt_pend_q <= vt_pend_d; found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d; best_q <= best_d; base_q <= base_d; scan_q <= scan_d;
    sel_q <= sel_d; ost_q <= ost_d; ocls_q <= ocls_d; otag_q <= otag_d;
  end

  assign out_valid_o = ovalid_q;
  assign out_data_o  = {tot_q, otag_q, ocls_q, ost_q};
endmodule

FILE: hdl/weighted_fair_queue_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_fair_queue_scheduler: WFQ scheduler with virtual-time clock
// Four class FIFOs of descriptors, finish tags, smallest-tag service.
// ----------------------------------------------------------------------------
//  channel | direction | transaction
//  s_axis  | in        | enqueue or dequeue request
//  m_axis  | out       | one result per request
//  cfg     | in        | register write (weights, capacity, link rate)
//
// With the sequencer free, an enqueue runs one division for its finish tag, and
// one more before it when virtual time moves (48-step divisions in the shared
// serial divider); a drop runs none. A dequeue runs one division when it serves
// and virtual time moves, the head scan reading the tag RAM one class a cycle.
// Reset clears all control state; the tag and descriptor RAMs are not cleared.
// A two-entry request queue takes inputs while the sequencer or m_axis stalls.
// ----------------------------------------------------------------------------
module weighted_fair_queue_scheduler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tuser: req_type
  input  logic        s_axis_tuser,
  // tdata: class_index[1:0], packet_bits[18:2], packet_tag[34:19], now_ticks[66:35]
  input  logic [71:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: status[1:0], served_class[3:2], served_tag[19:4], total_queued[28:20]
  output logic [31:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  logic [7:0]  weight_q [wfq_pkg::NumClasses];
  logic [6:0]  cap_q;
  logic [15:0] rate_q;
  wfq_pkg::req_t in_req, q_req;
  logic q_valid, q_pop;
  logic [28:0] odata;

  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < wfq_pkg::NumClasses; i++) weight_q[i] <= 8'd1;
      cap_q  <= '0;
      rate_q <= 16'd1000;
    end else if (cfg_valid_i) begin
      if (cfg_index_i <= wfq_pkg::RegWeight3)
        weight_q[cfg_index_i[1:0]] <= cfg_data_i[7:0];
      else if (cfg_index_i == wfq_pkg::RegCapacity) cap_q <= cfg_data_i[6:0];
      else if (cfg_index_i == wfq_pkg::RegLinkRate) rate_q <= cfg_data_i;
    end
  end

  assign in_req = '{req_type: s_axis_tuser, class_index: s_axis_tdata[1:0],
                    packet_bits: s_axis_tdata[18:2], packet_tag: s_axis_tdata[34:19],
                    now_ticks: s_axis_tdata[66:35]};

  wfq_front u_front (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready), .in_req_i(in_req), .q_valid_o(q_valid),
    .q_pop_i(q_pop), .q_req_o(q_req)
  );

  wfq_back u_back (
    .clk_i(clk_i), .rst_ni(rst_ni), .q_valid_i(q_valid), .q_pop_o(q_pop),
    .q_req_i(q_req), .weight_i(weight_q), .capacity_i(cap_q), .rate_i(rate_q),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_data_o(odata)
  );

  assign m_axis_tdata = {3'd0, odata};

  // Result is held while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed under stall");
  // Empty status carries no class or tag
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1:0] == wfq_pkg::StEmpty |-> m_axis_tdata[19:2] == '0)
    else $error("empty result with payload");
  // Enqueue results never carry a tag
  a_enq_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[1:0] == wfq_pkg::StAccepted ||
    m_axis_tdata[1:0] == wfq_pkg::StDropped) |-> m_axis_tdata[19:4] == '0)
    else $error("enqueue result with tag");
endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the weighted fair queue scheduler
// Requests go in as stream transactions; a scoreboard model computes virtual
// time, finish tags and class selection, and every result is checked in order.
// ----------------------------------------------------------------------------
module tb;

  localparam int CYCLE_LIMIT = 2000000;
  localparam logic [47:0] VT_SAT = 48'hFFFF_FFFF_FFFF;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic        s_axis_tuser = 1'b0;
  logic [71:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  always #4 clk_i = ~clk_i;

  weighted_fair_queue_scheduler DUT (.*);

  // result layout, highest bits first
  typedef struct packed {
    logic [8:0]  total_queued;
    logic [15:0] served_tag;
    logic [1:0]  served_class;
    logic [1:0]  status;
  } result_t;

  // ---- scheduler model state ----
  logic [7:0]  weight_q [wfq_pkg::NumClasses];
  logic [6:0]  capacity_q;
  logic [15:0] rate_q;
  logic [47:0] tag_mem [wfq_pkg::NumClasses][wfq_pkg::ClassDepth];
  logic [15:0] desc_mem [wfq_pkg::NumClasses][wfq_pkg::ClassDepth];
  logic [47:0] last_fin [wfq_pkg::NumClasses];
  int unsigned backlog [wfq_pkg::NumClasses];
  int unsigned head [wfq_pkg::NumClasses];
  int unsigned tail [wfq_pkg::NumClasses];
  int unsigned wsum;
  logic [47:0] vtime;
  logic [31:0] last_t;
  bit          idle;
  int unsigned queued;
  logic [31:0] now_cnt;   // time base for stimulus; it only advances, but for one reset to zero

  result_t     pending_results [$];
  int          mismatches;
  int unsigned cycles;

  function automatic logic [47:0] sat_add(logic [47:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {17'd0, a} + {1'b0, b};
    return (s > {17'd0, VT_SAT}) ? VT_SAT : s[47:0];
  endfunction

  function automatic int unsigned eff_weight(int c);
    return (weight_q[c] == 0) ? 1 : weight_q[c];
  endfunction

  function automatic void advance_vtime(logic [31:0] now);
    logic [63:0] elapsed;
    elapsed = (now >= last_t) ? 64'(now - last_t) : 64'd0;
    if (wsum != 0) vtime = sat_add(vtime, (elapsed << wfq_pkg::VtFracBits) / wsum);
    last_t = now;
  endfunction

  task automatic model_reset();
    for (int c = 0; c < wfq_pkg::NumClasses; c++) begin
      weight_q[c] = 8'd1; last_fin[c] = '0; backlog[c] = 0; head[c] = 0; tail[c] = 0;
    end
    capacity_q = 7'd0; rate_q = 16'd1000; wsum = 0; vtime = '0; last_t = '0;
    idle = 1; queued = 0;
  endtask

  // Computes the expected result of one request and updates the model
  function automatic result_t schedule_request(logic req, logic [1:0] cls,
                                               logic [16:0] bits, logic [15:0] ptag,
                                               logic [31:0] now);
    result_t r;
    int          sel;
    bit          found;
    logic [47:0] best, base;
    int unsigned w, rt;
    r = '0;
    if (req == wfq_pkg::ReqEnqueue) begin
      r.served_class = cls;
      if (backlog[cls] >= wfq_pkg::ClassDepth ||
          (capacity_q != 0 && backlog[cls] >= capacity_q)) begin
        r.status = wfq_pkg::StDropped;
      end else begin
        w  = eff_weight(cls);
        rt = (rate_q == 0) ? 1 : rate_q;
        if (idle) begin
          last_t = now; vtime = '0; idle = 0;
        end else begin
          advance_vtime(now);
        end
        base = (last_fin[cls] > vtime) ? last_fin[cls] : vtime;
        last_fin[cls] = sat_add(base, (64'(bits) << wfq_pkg::VtFracBits) /
                                      (64'(w) * 64'(rt)));
        tag_mem[cls][tail[cls]]  = last_fin[cls];
        desc_mem[cls][tail[cls]] = ptag;
        tail[cls] = (tail[cls] + 1) % wfq_pkg::ClassDepth;
        if (backlog[cls] == 0) begin
          wsum += w;
          if (wsum > wfq_pkg::SumMax) wsum = wfq_pkg::SumMax;
        end
        backlog[cls]++;
        queued++;
        r.status = wfq_pkg::StAccepted;
      end
    end else begin
      found = 0; sel = 0; best = '0;
      for (int c = 0; c < wfq_pkg::NumClasses; c++)
        if (backlog[c] != 0 && (!found || tag_mem[c][head[c]] < best)) begin
          found = 1; best = tag_mem[c][head[c]]; sel = c;
        end
      if (!found) begin
        r.status = wfq_pkg::StEmpty;
      end else begin
        r.served_tag   = desc_mem[sel][head[sel]];
        r.served_class = 2'(sel);
        head[sel] = (head[sel] + 1) % wfq_pkg::ClassDepth;
        advance_vtime(now);
        backlog[sel]--;
        if (backlog[sel] == 0) begin
          w = eff_weight(sel);
          wsum = (wsum > w) ? wsum - w : 0;
        end
        if (wsum == 0) begin
          idle = 1;
          for (int c = 0; c < wfq_pkg::NumClasses; c++) last_fin[c] = '0;
        end
        if (queued != 0) queued--;
        r.status = wfq_pkg::StDequeued;
      end
    end
    r.total_queued = 9'(queued);
    return r;
  endfunction

  // ---- stimulus helpers ----
  int unsigned burst_left;

  // Sends one request; the model is updated at acceptance time.
  // tvalid stays high within a burst and drops for a gap.
  task automatic send_request(logic req, logic [1:0] cls, logic [16:0] bits,
                              logic [15:0] ptag, logic [31:0] now);
    result_t res;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if ($urandom_range(0, 2) != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 30)) @(negedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {5'd0, now, ptag, bits, cls};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    res = schedule_request(req, cls, bits, ptag, now);
    pending_results.insert(pending_results.size(), res);
    @(negedge clk_i);
  endtask

  task automatic enqueue(logic [1:0] cls, logic [16:0] bits, logic [15:0] ptag);
    now_cnt += $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 5000);
    send_request(wfq_pkg::ReqEnqueue, cls, bits, ptag, now_cnt);
  endtask

  task automatic dequeue();
    now_cnt += $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 5000);
    send_request(wfq_pkg::ReqDequeue, 2'($urandom), 17'($urandom), 16'($urandom), now_cnt);
  endtask

  // Waits for the block to drain before a register transaction
  task automatic wait_quiet();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (150) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      wfq_pkg::RegCapacity: capacity_q = val[6:0];
      wfq_pkg::RegLinkRate: rate_q     = val;
      default:              weight_q[idx[1:0]] = val[7:0];
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic drain_all();
    while (queued != 0) dequeue();
  endtask

  // ---- tests ----
  task automatic test_directed();
    dequeue();                                     // nothing queued
    enqueue(2'd0, 17'd1, 16'h0000);                // smallest packet
    enqueue(2'd1, 17'h1FFFF, 16'hFFFF);            // largest packet, all-ones tag
    enqueue(2'd2, 17'd1000, 16'hA5A5);
    enqueue(2'd3, 17'd1000, 16'h5A5A);             // same size as class 2: equal tags if no time elapsed
    enqueue(2'd2, 17'd1000, 16'h1234);
    // time going backwards counts as no elapsed time
    send_request(wfq_pkg::ReqEnqueue, 2'd3, 17'd77, 16'h0F0F, now_cnt - 32'd100);
    repeat (7) dequeue();                          // past empty
    // elapsed time at its widest
    send_request(wfq_pkg::ReqEnqueue, 2'd1, 17'd5, 16'h00FF, 32'd0);
    send_request(wfq_pkg::ReqEnqueue, 2'd0, 17'd5, 16'hFF00, 32'hFFFF_FFFF);
    send_request(wfq_pkg::ReqDequeue, 2'd0, 17'd0, 16'd0, 32'hFFFF_FFFF);
    send_request(wfq_pkg::ReqDequeue, 2'd0, 17'd0, 16'd0, 32'hFFFF_FFFF);
    now_cnt = 0;
  endtask

  task automatic test_config_extremes();
    wait_quiet();
    write_reg(wfq_pkg::RegCapacity, 16'd2);
    write_reg(wfq_pkg::RegLinkRate, 16'd1);        // huge tag increments
    write_reg(wfq_pkg::RegWeight0, 16'd255);
    write_reg(3'd1, 16'd1);
    write_reg(3'd2, 16'd0);                        // zero weight acts as one
    write_reg(wfq_pkg::RegWeight3, 16'd128);
    for (int i = 0; i < 3; i++)
      for (int c = 0; c < wfq_pkg::NumClasses; c++)
        enqueue(2'(c), 17'h1FFFF, 16'($urandom));
    drain_all();
    dequeue();
    wait_quiet();
    write_reg(wfq_pkg::RegCapacity, 16'd0);        // only the physical depth limits
    write_reg(wfq_pkg::RegLinkRate, 16'hFFFF);
    for (int i = 0; i < 66; i++) enqueue(2'd1, 17'($urandom_range(1, 131071)), 16'(i));
    // weight changed while backlogged
    wait_quiet();
    write_reg(3'd1, 16'd200);
    drain_all();
  endtask

  // Well-formed enqueue/dequeue traffic with random content
  task automatic test_random(int n, bit wide);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < (queued > 40 ? 60 : 45)) dequeue();
      else enqueue(2'($urandom),
                   wide ? 17'($urandom_range(1, 131071)) : 17'($urandom_range(1, 12000)),
                   16'($urandom));
    end
  endtask

  task automatic test_random_settings();
    for (int p = 0; p < 5; p++) begin
      wait_quiet();
      for (int c = 0; c < wfq_pkg::NumClasses; c++)
        write_reg(3'(c), p == 4 ? 16'd255 : 16'($urandom_range(0, 255)));
      write_reg(wfq_pkg::RegCapacity, 16'($urandom_range(0, 70)));
      write_reg(wfq_pkg::RegLinkRate, p == 0 ? 16'd1 : 16'($urandom_range(0, 65535)));
      test_random(255, p[0]);
    end
    drain_all();
  endtask

  // ---- result checker ----
  initial begin
    result_t got, exp;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[28:0];
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", got);
        end else begin
          exp = pending_results.pop_front();
          if (got !== exp) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp st=%0d cls=%0d tag=%h q=%0d, got st=%0d cls=%0d tag=%h q=%0d",
                       exp.status, exp.served_class, exp.served_tag, exp.total_queued,
                       got.status, got.served_class, got.served_tag, got.total_queued);
          end
        end
      end
    end
  end

  // receiver stall pattern: free-running stretches and random back-pressure
  initial begin
    forever begin
      @(negedge clk_i);
      case ($urandom_range(0, 3))
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
        default: m_axis_tready <= ($urandom_range(0, 1) == 0) ? m_axis_tready : ~m_axis_tready;
      endcase
    end
  end

  // watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("FAIL weighted_fair_queue_scheduler");
        $finish;
      end
    end
  end

  initial begin
    mismatches = 0; burst_left = 0; now_cnt = 0;
    model_reset();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_config_extremes();
    test_random_settings();
    wait_quiet();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASS weighted_fair_queue_scheduler");
    end else begin
      $display("FAIL weighted_fair_queue_scheduler");
    end
    $finish;
  end

endmodule
